FILE: hw/rtl/fbr_pkg.sv
// fbr_pkg: shared types, codes and constants of the framed byte receiver
// no dependencies; imported by every module of the block
package fbr_pkg;

	localparam int FRAME_CAPACITY_DEF = 64;
	localparam int MIN_FRAME_LEN      = 3;
	localparam int CFG_IDX_W          = 8;
	localparam int ADDR_MAX_W         = 8;

	localparam logic [7:0] START_MARKER_RST = 8'h02;
	localparam logic [7:0] END_MARKER_RST   = 8'h03;

	typedef enum logic [1:0] {
		FUNC_BYTE    = 2'd0,
		FUNC_TIMEOUT = 2'd1,
		FUNC_READ    = 2'd2,
		FUNC_RELEASE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IGNORED = 2'd0,
		ST_STORED  = 2'd1,
		ST_DONE    = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START = 8'd0,
		REG_END   = 8'd1
	} reg_idx_t;

	// store access for one accepted word
	typedef struct packed {
		logic                  we;
		logic [ADDR_MAX_W-1:0] waddr;
		logic [7:0]            wdata;
		logic                  re;
		logic [ADDR_MAX_W-1:0] raddr;
	} fbr_mem_req_t;

	// result fields known at the end of the control step
	typedef struct packed {
		status_t    status;
		logic       frame_ready;
		logic [6:0] frame_length;
		logic       rd_sel;
	} fbr_resp_t;

endpackage

FILE: hw/rtl/fbr_if.sv
// fbr_in_if, fbr_out_if, fbr_cfg_if: valid/ready channels of the receiver
// depends on fbr_pkg for the register index width
interface fbr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic [5:0] read_index;

	modport source (output valid, output func, output data_byte, output read_index,
		input ready);
	modport sink (input valid, input func, input data_byte, input read_index,
		output ready);
endinterface

interface fbr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] byte_status;
	logic       frame_ready;
	logic [6:0] frame_length;
	logic [7:0] read_byte;

	modport source (output valid, output byte_status, output frame_ready,
		output frame_length, output read_byte, input ready);
	modport sink (input valid, input byte_status, input frame_ready,
		input frame_length, input read_byte, output ready);
endinterface

interface fbr_cfg_if;
	import fbr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [7:0]           wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: hw/rtl/fbr_store.sv
// fbr_store: frame byte memory, one write and one registered read port
// depends on fbr_pkg for the access struct
module fbr_store
	import fbr_pkg::*;
#(
	parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
	input  logic         clk,
	input  fbr_mem_req_t req,
	output logic [7:0]   rd_data
);
	localparam int AW = $clog2(FRAME_CAPACITY);

	logic [7:0] store_q [FRAME_CAPACITY];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			store_q[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= store_q[req.raddr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/fbr_ctrl.sv
// fbr_ctrl: frame assembly state and per-word decisions
// depends on fbr_pkg; drives the store access of fbr_store
module fbr_ctrl
	import fbr_pkg::*;
#(
	parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic [1:0]   func,
	input  logic [7:0]   data_byte,
	input  logic [5:0]   read_index,
	input  logic [7:0]   start_marker,
	input  logic [7:0]   end_marker,
	output fbr_resp_t    resp,
	output fbr_mem_req_t mem_req
);
	localparam int AW = $clog2(FRAME_CAPACITY);

	logic [AW-1:0] wp_q, wp_d;
	logic [7:0]    len_q, len_d;
	logic          rdy_q, rdy_d;
	status_t       status;
	logic          rd_sel;
	fbr_mem_req_t  req;
	logic          pos_over, len_bad, at_end, idx_ok;

	assign pos_over = 9'(wp_q) >= 9'(FRAME_CAPACITY);
	assign len_bad  = (9'(data_byte) < 9'(MIN_FRAME_LEN)) ||
		(9'(data_byte) > 9'(FRAME_CAPACITY));
	assign at_end   = (9'(wp_q) + 9'd1) == 9'(len_q);
	assign idx_ok   = 9'(read_index) < 9'(FRAME_CAPACITY);

	always_comb begin
		wp_d      = wp_q;
		len_d     = len_q;
		rdy_d     = rdy_q;
		status    = ST_IGNORED;
		rd_sel    = 1'b0;
		req       = '0;
		req.waddr = ADDR_MAX_W'(wp_q);
		req.wdata = data_byte;
		req.raddr = ADDR_MAX_W'(read_index);
		case (func_t'(func))
			FUNC_BYTE: begin
				if (!rdy_q) begin
					if (pos_over) begin
						wp_d   = '0;
						status = ST_DROPPED;
					end else if (wp_q == '0) begin
						if (data_byte == start_marker) begin
							req.we = 1'b1;
							wp_d   = AW'(1);
							status = ST_STORED;
						end
					end else if (wp_q == AW'(1)) begin
						if (len_bad) begin
							wp_d   = '0;
							status = ST_DROPPED;
						end else begin
							req.we = 1'b1;
							len_d  = data_byte;
							wp_d   = AW'(2);
							status = ST_STORED;
						end
					end else if (at_end) begin
						wp_d = '0;
						if (data_byte == end_marker) begin
							req.we = 1'b1;
							rdy_d  = 1'b1;
							status = ST_DONE;
						end else begin
							status = ST_DROPPED;
						end
					end else begin
						req.we = 1'b1;
						wp_d   = wp_q + AW'(1);
						status = ST_STORED;
					end
				end
			end
			FUNC_TIMEOUT: begin
				if (!rdy_q) begin
					wp_d = '0;
				end
			end
			FUNC_READ: begin
				if (idx_ok) begin
					req.re = 1'b1;
					rd_sel = 1'b1;
				end
			end
			FUNC_RELEASE: begin
				rdy_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			len_q <= '0;
			rdy_q <= 1'b0;
		end else if (fire) begin
			wp_q  <= wp_d;
			len_q <= len_d;
			rdy_q <= rdy_d;
		end
	end

	always_comb begin
		mem_req    = req;
		mem_req.we = req.we & fire;
		mem_req.re = req.re & fire;
	end

	assign resp.status       = status;
	assign resp.frame_ready  = rdy_d;
	assign resp.frame_length = len_d[6:0];
	assign resp.rd_sel       = rd_sel;

endmodule

FILE: hw/rtl/framed_byte_receiver.sv
// framed_byte_receiver: length-prefixed frame receiver, top level
// depends on fbr_pkg, the fbr interfaces, fbr_ctrl and fbr_store
//
// Takes one word per clock on in_ch and returns exactly one result word on
// out_ch for each. A frame is start marker, length byte (whole frame, 3 up
// to FRAME_CAPACITY), payload and end marker; its bytes land in an on-chip
// byte store, and software reads them back by index with the read function
// and frees the block for the next frame with the release function. Rate:
// one word per cycle sustained while out_ch takes every result; each result
// appears in the cycle after its word is taken. The control update and the
// store's registered read port keep up with it; a write and a later read of
// the same entry never overlap, so no forwarding is needed. The result stage
// is one register: while it holds an unread word, in_ch waits. The store
// needs no clearing after reset; reading a position that was never written
// gives an undefined byte. Configuration writes (start and end marker) are
// always taken and belong to idle periods.
module framed_byte_receiver
	import fbr_pkg::*;
#(
	parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fbr_cfg_if.sink   cfg_ch,
	fbr_in_if.sink    in_ch,
	fbr_out_if.source out_ch
);

	// marker registers
	logic [7:0] start_q;
	logic [7:0] end_q;

	// result stage
	logic       out_v_s1;
	status_t    status_s1;
	logic       rdy_s1;
	logic [6:0] len_s1;
	logic       rd_sel_s1;

	logic         fire;
	fbr_resp_t    resp;
	fbr_mem_req_t mem_req;
	logic [7:0]   rd_data;

	// config port never stalls
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_MARKER_RST;
			end_q   <= END_MARKER_RST;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.reg_index == REG_START) begin
				start_q <= cfg_ch.wdata;
			end else if (cfg_ch.reg_index == REG_END) begin
				end_q <= cfg_ch.wdata;
			end
		end
	end

	// take a new word whenever the result stage is free or being drained
	assign in_ch.ready = !out_v_s1 || out_ch.ready;
	assign fire        = in_ch.valid && in_ch.ready;

	fbr_ctrl #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.func        (in_ch.func),
		.data_byte   (in_ch.data_byte),
		.read_index  (in_ch.read_index),
		.start_marker(start_q),
		.end_marker  (end_q),
		.resp        (resp),
		.mem_req     (mem_req)
	);

	// read data lands in the store's output register together with the
	// result stage, and both hold while out_ch stalls
	fbr_store #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_store (
		.clk    (clk),
		.req    (mem_req),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			out_v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1 <= resp.status;
			rdy_s1    <= resp.frame_ready;
			len_s1    <= resp.frame_length;
			rd_sel_s1 <= resp.rd_sel;
		end
	end

	assign out_ch.valid        = out_v_s1;
	assign out_ch.byte_status  = status_s1;
	assign out_ch.frame_ready  = rdy_s1;
	assign out_ch.frame_length = len_s1;
	// non-read words and out-of-range reads show zero
	assign out_ch.read_byte    = rd_sel_s1 ? rd_data : 8'h00;

endmodule

FILE: hw/rtl/fbr_checker.sv
// fbr_checker: port-level assertions of the framed byte receiver
// depends on fbr_pkg for codes; bound to framed_byte_receiver below
module fbr_checker
	import fbr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_byte_status,
	input logic       out_frame_ready,
	input logic [6:0] out_frame_length,
	input logic [7:0] out_read_byte
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte_status) &&
		$stable(out_frame_ready) && $stable(out_frame_length) && $stable(out_read_byte))
		else $error("result word changed while stalled");

	// a stalled result blocks the input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stage is full");

	// every taken word shows a result next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word produced no result");

	// release clears the ready flag
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_func == FUNC_RELEASE) |=> !out_frame_ready)
		else $error("frame still ready after release");

endmodule

bind framed_byte_receiver fbr_checker u_fbr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.in_func         (in_ch.func),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_byte_status (out_ch.byte_status),
	.out_frame_ready (out_ch.frame_ready),
	.out_frame_length(out_ch.frame_length),
	.out_read_byte   (out_ch.read_byte)
);

FILE: verif/framed_byte_receiver_test.sv
// framed_byte_receiver_test: self-checking bench for the framed byte receiver
// depends on fbr_pkg, the fbr channel interfaces and the framed_byte_receiver rtl
// a shadow of the frame state predicts every result word; random frames drive it deep
module framed_byte_receiver_test;
	import fbr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP         = FRAME_CAPACITY_DEF;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 260;
	localparam int STALL_LIMIT = 500;

	// one word offered on in_ch
	typedef struct packed {
		func_t      func;
		logic [7:0] data_byte;
		logic [5:0] read_index;
	} rx_word_t;

	// one word returned on out_ch
	typedef struct packed {
		status_t    byte_status;
		logic       frame_ready;
		logic [6:0] frame_length;
		logic [7:0] read_byte;
	} rx_reply_t;

	// markers, frame progress and the byte store, with a mask of filled entries
	typedef struct packed {
		logic [7:0]       start_mk;
		logic [7:0]       end_mk;
		logic [6:0]       wr_pos;
		logic [6:0]       len_seen;
		logic             ready;
		logic [CAP-1:0]   filled;
		logic [CAP-1:0][7:0] store;
	} frame_state_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fbr_cfg_if cfg_ch ();
	fbr_in_if  in_ch ();
	fbr_out_if out_ch ();

	framed_byte_receiver #(.FRAME_CAPACITY(CAP)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// words still to be offered, replies still to come
	rx_word_t  word_q[$];
	rx_reply_t reply_q[$];

	// live_st follows accepted words, plan_st follows words as they are queued
	frame_state_t live_st;
	frame_state_t plan_st;

	int errors      = 0;
	int phase_items = 0;
	int send_odds   = 6;
	int recv_odds   = 6;
	int send_gap    = 0;
	int recv_gap    = 0;
	int stall_cycles;

	rx_word_t  took_word;
	rx_reply_t took_reply;
	rx_reply_t want;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic frame_state_t fresh_state();
		frame_state_t st;
		st          = '0;
		st.start_mk = START_MARKER_RST;
		st.end_mk   = END_MARKER_RST;
		return st;
	endfunction

	// advance the frame state by one word and give the reply it causes
	function automatic rx_reply_t frame_step(inout frame_state_t st, input rx_word_t w);
		rx_reply_t  r;
		logic [6:0] at;
		r  = '0;
		at = st.wr_pos;
		case (w.func)
			FUNC_BYTE: begin
				if (st.ready) begin
					// frame waiting for release, byte is ignored
					r.byte_status = ST_IGNORED;
				end else if (at >= CAP) begin
					st.wr_pos     = '0;
					r.byte_status = ST_DROPPED;
				end else if (at == 0) begin
					// hunting for the start marker
					if (w.data_byte == st.start_mk) begin
						st.store[0]   = w.data_byte;
						st.filled[0]  = 1'b1;
						st.wr_pos     = 7'd1;
						r.byte_status = ST_STORED;
					end else begin
						r.byte_status = ST_IGNORED;
					end
				end else if (at == 1) begin
					// length byte, must lie in 3..capacity
					if (w.data_byte < MIN_FRAME_LEN || w.data_byte > CAP) begin
						st.wr_pos     = '0;
						r.byte_status = ST_DROPPED;
					end else begin
						st.len_seen   = w.data_byte[6:0];
						st.store[1]   = w.data_byte;
						st.filled[1]  = 1'b1;
						st.wr_pos     = 7'd2;
						r.byte_status = ST_STORED;
					end
				end else if (at + 7'd1 == st.len_seen) begin
					// last position: end marker completes, anything else drops
					st.wr_pos = '0;
					if (w.data_byte == st.end_mk) begin
						st.store[at[5:0]]  = w.data_byte;
						st.filled[at[5:0]] = 1'b1;
						st.ready           = 1'b1;
						r.byte_status      = ST_DONE;
					end else begin
						r.byte_status = ST_DROPPED;
					end
				end else begin
					st.store[at[5:0]]  = w.data_byte;
					st.filled[at[5:0]] = 1'b1;
					st.wr_pos          = at + 7'd1;
					r.byte_status      = ST_STORED;
				end
			end
			FUNC_TIMEOUT: begin
				if (!st.ready)
					st.wr_pos = '0;
			end
			FUNC_READ: begin
				if (w.read_index < CAP)
					r.read_byte = st.store[w.read_index];
			end
			default: begin
				st.ready = 1'b0;
			end
		endcase
		r.frame_ready  = st.ready;
		r.frame_length = st.len_seen;
		return r;
	endfunction

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [5:0] rnd_index();
		return 6'($urandom_range(0, CAP - 1));
	endfunction

	// queue one word and count it
	task automatic queue_word(input func_t f, input logic [7:0] b, input logic [5:0] ix);
		rx_word_t  w;
		w.func       = f;
		w.data_byte  = b;
		w.read_index = ix;
		void'(frame_step(plan_st, w));
		word_q.push_back(w);
		phase_items++;
	endtask

	// read back a random entry that has been written at least once
	task automatic queue_read();
		int first;
		int k;
		int ix;
		first = $urandom_range(0, CAP - 1);
		for (k = 0; k < CAP; k++) begin
			ix = (first + k) % CAP;
			if (plan_st.filled[ix]) begin
				queue_word(FUNC_READ, rnd_byte(), 6'(ix));
				return;
			end
		end
	endtask

	// one frame with random content, now and then broken on purpose
	task automatic queue_frame();
		int         len;
		int         p;
		int         n;
		logic [7:0] b;
		// get back to the start marker hunt first
		if (plan_st.ready)
			queue_word(FUNC_RELEASE, rnd_byte(), rnd_index());
		if (plan_st.wr_pos != 0)
			queue_word(FUNC_TIMEOUT, rnd_byte(), rnd_index());
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
		repeat (n) begin
			b = rnd_byte();
			if (b != plan_st.start_mk)
				queue_word(FUNC_BYTE, b, rnd_index());
		end
		queue_word(FUNC_BYTE, plan_st.start_mk, rnd_index());
		case ($urandom_range(0, 19))
			0:       len = $urandom_range(0, MIN_FRAME_LEN - 1);
			1:       len = $urandom_range(CAP + 1, 255);
			2, 3:    len = CAP;
			4:       len = $urandom_range(MIN_FRAME_LEN, CAP);
			default: len = $urandom_range(MIN_FRAME_LEN, 12);
		endcase
		queue_word(FUNC_BYTE, 8'(len), rnd_index());
		if (len < MIN_FRAME_LEN || len > CAP)
			return;
		for (p = 2; p < len - 1; p++) begin
			// receive timeout in the middle of the payload
			if ($urandom_range(0, 59) == 0) begin
				queue_word(FUNC_TIMEOUT, rnd_byte(), rnd_index());
				return;
			end
			queue_word(FUNC_BYTE, rnd_byte(), rnd_index());
		end
		if ($urandom_range(0, 9) == 0)
			b = plan_st.end_mk ^ 8'($urandom_range(1, 255));
		else
			b = plan_st.end_mk;
		queue_word(FUNC_BYTE, b, rnd_index());
		// poke the finished frame: late bytes, timeout, reads, release
		repeat ($urandom_range(0, 2))
			queue_word(FUNC_BYTE, rnd_byte(), rnd_index());
		if ($urandom_range(0, 3) == 0)
			queue_word(FUNC_TIMEOUT, rnd_byte(), rnd_index());
		repeat ($urandom_range(1, 4))
			queue_read();
		if ($urandom_range(0, 4) != 0)
			queue_word(FUNC_RELEASE, rnd_byte(), rnd_index());
	endtask

	// any function with random fields
	task automatic queue_noise();
		case ($urandom_range(0, 3))
			0: queue_word(FUNC_BYTE, rnd_byte(), rnd_index());
			1: queue_word(FUNC_TIMEOUT, rnd_byte(), rnd_index());
			2: queue_read();
			default: queue_word(FUNC_RELEASE, rnd_byte(), rnd_index());
		endcase
	endtask

	// sender holds off until every queued word is sent and every reply is back
	task automatic drain();
		do
			@(negedge clk);
		while (word_q.size() != 0 || reply_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
		@(posedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata     <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_START: plan_st.start_mk = v;
			REG_END:   plan_st.end_mk   = v;
			default:   ;
		endcase
	endtask

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return 12;
		endcase
	endfunction

	// driver: offers the head of word_q, keeps the live shadow in step with accepted words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid      <= 1'b0;
			in_ch.func       <= FUNC_BYTE;
			in_ch.data_byte  <= '0;
			in_ch.read_index <= '0;
			send_gap = 0;
			live_st  = fresh_state();
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.reg_index)
					REG_START: live_st.start_mk = cfg_ch.wdata;
					REG_END:   live_st.end_mk   = cfg_ch.wdata;
					default:   ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				took_word  = word_q.pop_front();
				took_reply = frame_step(live_st, took_word);
				reply_q.push_back(took_reply);
			end
			if (in_ch.valid && !in_ch.ready) begin
				// word still on offer, keep it there
			end else if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
			end else if (word_q.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (send_odds != 0 && $urandom_range(0, send_odds) == 0) begin
				// idle burst of random length
				send_gap = $urandom_range(0, 14);
				in_ch.valid <= 1'b0;
			end else begin
				in_ch.valid      <= 1'b1;
				in_ch.func       <= word_q[0].func;
				in_ch.data_byte  <= word_q[0].data_byte;
				in_ch.read_index <= word_q[0].read_index;
			end
		end
	end

	// monitor: takes reply words, checks each against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (reply_q.size() == 0) begin
					errors++;
					$display("%0t: reply word with nothing expected, got status %0d ready %0d",
						$time, out_ch.byte_status, out_ch.frame_ready);
				end else begin
					want = reply_q.pop_front();
					check_field("byte_status", want.byte_status, out_ch.byte_status);
					check_field("frame_ready", want.frame_ready, out_ch.frame_ready);
					check_field("frame_length", want.frame_length, out_ch.frame_length);
					check_field("read_byte", want.read_byte, out_ch.read_byte);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ch.ready <= 1'b0;
			end else if (recv_odds != 0 && $urandom_range(0, recv_odds) == 0) begin
				recv_gap = $urandom_range(0, 14);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: too long without any word moving on any channel
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("framed_byte_receiver_test: FAIL");
		$finish;
	end

	// stimulus: directed frames under reset markers, then marker phases of random frames
	initial begin
		logic [7:0] start_list [PHASES];
		logic [7:0] end_list [PHASES];
		int         ph;
		start_list = '{8'h02, 8'h00, 8'hFF, 8'hA5, 8'hFF, 8'h00, 8'h00};
		end_list   = '{8'h03, 8'hFF, 8'h00, 8'hA5, 8'hFF, 8'h00, 8'h00};
		in_ch.valid      = 1'b0;
		in_ch.func       = FUNC_BYTE;
		in_ch.data_byte  = '0;
		in_ch.read_index = '0;
		out_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.reg_index = REG_START;
		cfg_ch.wdata     = '0;
		live_st = fresh_state();
		plan_st = fresh_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// release and timeout with no frame around
		queue_word(FUNC_RELEASE, 8'h00, 6'h00);
		queue_word(FUNC_TIMEOUT, 8'hFF, 6'h3F);
		// noise before any start marker
		queue_word(FUNC_BYTE, 8'h00, 6'h3F);
		queue_word(FUNC_BYTE, 8'hFF, 6'h00);
		// lengths below and above the allowed range
		queue_word(FUNC_BYTE, START_MARKER_RST, 6'h00);
		queue_word(FUNC_BYTE, 8'd2, 6'h00);
		queue_word(FUNC_BYTE, START_MARKER_RST, 6'h00);
		queue_word(FUNC_BYTE, 8'd65, 6'h00);
		// wrong byte where the end marker belongs
		queue_word(FUNC_BYTE, START_MARKER_RST, 6'h00);
		queue_word(FUNC_BYTE, 8'd4, 6'h00);
		queue_word(FUNC_BYTE, 8'hAA, 6'h00);
		queue_word(FUNC_BYTE, 8'h55, 6'h00);
		// shortest frame, then poke it while it waits
		queue_word(FUNC_BYTE, START_MARKER_RST, 6'h00);
		queue_word(FUNC_BYTE, 8'd3, 6'h00);
		queue_word(FUNC_BYTE, END_MARKER_RST, 6'h00);
		queue_word(FUNC_BYTE, START_MARKER_RST, 6'h00);
		queue_word(FUNC_TIMEOUT, 8'h00, 6'h00);
		queue_word(FUNC_READ, 8'hFF, 6'h00);
		queue_word(FUNC_READ, 8'h00, 6'h02);
		queue_word(FUNC_RELEASE, 8'h00, 6'h00);
		queue_word(FUNC_RELEASE, 8'h00, 6'h00);
		// timeout in the middle of a frame
		queue_word(FUNC_BYTE, START_MARKER_RST, 6'h00);
		queue_word(FUNC_BYTE, 8'd5, 6'h00);
		queue_word(FUNC_TIMEOUT, 8'h00, 6'h00);
		queue_word(FUNC_BYTE, 8'hFF, 6'h00);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1) begin
				// last stretch: random markers and no idling at all
				start_list[ph] = rnd_byte();
				end_list[ph]   = rnd_byte();
				send_odds = 0;
				recv_odds = 0;
			end else begin
				send_odds = pick_odds();
				recv_odds = pick_odds();
			end
			write_reg(REG_START, start_list[ph]);
			write_reg(REG_END, end_list[ph]);
			@(negedge clk);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 7)
					queue_frame();
				else
					queue_noise();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("framed_byte_receiver_test: PASS");
		else
			$display("framed_byte_receiver_test: FAIL");
		$finish;
	end

endmodule

FILE: framed_byte_receiver.f
hw/rtl/fbr_pkg.sv
hw/rtl/fbr_if.sv
hw/rtl/fbr_store.sv
hw/rtl/fbr_ctrl.sv
hw/rtl/framed_byte_receiver.sv
hw/rtl/fbr_checker.sv
verif/framed_byte_receiver_test.sv
